/* sv/bsrl_pkg.sv */
// shared types and constants of the bounded sorted record list
package bsrl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 7;
  localparam int ENT_W        = 7;
  localparam int ACT_W        = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_END    = 3'd0,
    ACT_INS_FRONT  = 3'd1,
    ACT_INS_SORTED = 3'd2,
    ACT_READ_POS   = 3'd3,
    ACT_FIND_KEY   = 3'd4,
    ACT_REM_END    = 3'd5,
    ACT_REM_FRONT  = 3'd6,
    ACT_REM_KEY    = 3'd7
  } action_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] key;
    logic [WORD_W-1:0]        word_one;
    logic [WORD_W-1:0]        word_two;
    logic [WORD_W-1:0]        word_three;
  } rec_t;

endpackage

/* sv/bsrl_if.sv */
// request and response channel interfaces of the record list
interface bsrl_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] key;
  logic [31:0]        word_one;
  logic [31:0]        word_two;
  logic [31:0]        word_three;
  logic [6:0]         position;

  modport source (output valid, action, key, word_one, word_two, word_three, position,
                  input ready);
  modport sink   (input valid, action, key, word_one, word_two, word_three, position,
                  output ready);
endinterface

interface bsrl_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] out_key;
  logic [31:0]        out_word_one;
  logic [31:0]        out_word_two;
  logic [31:0]        out_word_three;
  logic [6:0]         entries;
  logic               is_full;
  logic               is_empty;

  modport source (output valid, ok, out_key, out_word_one, out_word_two, out_word_three,
                  entries, is_full, is_empty, input ready);
  modport sink   (input valid, ok, out_key, out_word_one, out_word_two, out_word_three,
                  entries, is_full, is_empty, output ready);
endinterface

/* sv/bsrl_mem.sv */
// record storage: one write port, one read port with registered read data
module bsrl_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  bsrl_pkg::rec_t   wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output bsrl_pkg::rec_t   rdata_o
);
  import bsrl_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bsrl_ctrl.sv */
// sequencer: scans and shifts records through the memory, holds the result register
module bsrl_ctrl #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7,
  parameter int IDX_W    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bsrl_req_if.sink         req,
  bsrl_rsp_if.source       rsp,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output bsrl_pkg::rec_t   mem_wdata_o,
  output logic             mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  bsrl_pkg::rec_t   mem_rdata_i
);
  import bsrl_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_SHUP, S_PUT, S_SHDN, S_RDW, S_FIN
  } state_e;

  state_e            state_q, state_d;
  action_e           act_q, act_d;
  rec_t              nrec_q, nrec_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [CNT_W-1:0]  ia_q, ia_d;
  logic [CNT_W-1:0]  ridx_q, ridx_d;
  logic              iss_q, iss_d;
  logic              rv_q, rv_d;
  logic              ok_q, ok_d;
  rec_t              shown_q, shown_d;
  logic              ov_q, ov_d;
  logic              out_ok_q, out_ok_d;
  rec_t              out_rec_q, out_rec_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic [CNT_W-1:0]  cnt_m1, ia_p1, ia_m1, ridx_p1, ridx_m1;
  logic [CMP_W-1:0]  pos_w, cnt_w, pos_m1;
  logic              is_full, is_empty, pos_ok, hit, last;

  function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] v);
    return v[IDX_W-1:0];
  endfunction

  assign cnt_m1   = cnt_q - ONE_C;
  assign ia_p1    = ia_q + ONE_C;
  assign ia_m1    = ia_q - ONE_C;
  assign ridx_p1  = ridx_q + ONE_C;
  assign ridx_m1  = ridx_q - ONE_C;
  assign is_full  = (cnt_q == CAP_C);
  assign is_empty = (cnt_q == '0);
  assign pos_w    = CMP_W'(pos_q);
  assign cnt_w    = CMP_W'(cnt_q);
  assign pos_m1   = pos_w - CMP_W'(1);
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign last     = (ridx_q == cnt_m1);

  // sorted insert stops at the first key not smaller, the others at an equal key
  always_comb begin
    if (act_q == ACT_INS_SORTED) begin
      hit = ($signed(mem_rdata_i.key) >= $signed(nrec_q.key));
    end else begin
      hit = (mem_rdata_i.key == nrec_q.key);
    end
  end

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    nrec_d    = nrec_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    tgt_d     = tgt_q;
    ia_d      = ia_q;
    ridx_d    = ridx_q;
    iss_d     = iss_q;
    rv_d      = rv_q;
    ok_d      = ok_q;
    shown_d   = shown_q;
    ov_d      = ov_q;
    out_ok_d  = out_ok_q;
    out_rec_d = out_rec_q;
    out_cnt_d = out_cnt_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = nrec_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    if (ov_q && rsp.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          act_d              = action_e'(req.action);
          nrec_d.key         = req.key;
          nrec_d.word_one    = req.word_one;
          nrec_d.word_two    = req.word_two;
          nrec_d.word_three  = req.word_three;
          pos_d              = req.position;
          state_d            = S_START;
        end
      end

      S_START: begin
        ok_d    = 1'b0;
        shown_d = '0;
        iss_d   = 1'b0;
        rv_d    = 1'b0;
        state_d = S_FIN;
        unique case (act_q)
          ACT_INS_END: begin
            if (!is_full) begin
              tgt_d   = cnt_q;
              state_d = S_PUT;
            end
          end
          ACT_INS_FRONT: begin
            if (!is_full) begin
              tgt_d = '0;
              if (is_empty) begin
                state_d = S_PUT;
              end else begin
                ia_d    = cnt_m1;
                iss_d   = 1'b1;
                state_d = S_SHUP;
              end
            end
          end
          ACT_INS_SORTED: begin
            if (!is_full) begin
              if (is_empty) begin
                tgt_d   = '0;
                state_d = S_PUT;
              end else begin
                ia_d    = '0;
                iss_d   = 1'b1;
                state_d = S_SCAN;
              end
            end
          end
          ACT_READ_POS: begin
            if (pos_ok) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_m1[IDX_W-1:0];
              state_d     = S_RDW;
            end
          end
          ACT_FIND_KEY, ACT_REM_KEY: begin
            if (!is_empty) begin
              ia_d    = '0;
              iss_d   = 1'b1;
              state_d = S_SCAN;
            end
          end
          ACT_REM_END: begin
            if (!is_empty) begin
              cnt_d = cnt_m1;
              ok_d  = 1'b1;
            end
          end
          ACT_REM_FRONT: begin
            if (!is_empty) begin
              if (cnt_q == ONE_C) begin
                cnt_d = '0;
                ok_d  = 1'b1;
              end else begin
                tgt_d   = '0;
                ia_d    = ONE_C;
                iss_d   = 1'b1;
                state_d = S_SHDN;
              end
            end
          end
          default: state_d = S_FIN;
        endcase
      end

      S_SCAN: begin
        // reads run one ahead of the compare
        rv_d = iss_q;
        if (iss_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = to_idx(ia_q);
          ridx_d      = ia_q;
          if (ia_q == cnt_m1) begin
            iss_d = 1'b0;
          end else begin
            ia_d = ia_p1;
          end
        end
        if (rv_q && (hit || last)) begin
          iss_d   = 1'b0;
          rv_d    = 1'b0;
          state_d = S_FIN;
          case (act_q)
            ACT_INS_SORTED: begin
              if (hit) begin
                tgt_d   = ridx_q;
                ia_d    = cnt_m1;
                iss_d   = 1'b1;
                state_d = S_SHUP;
              end else begin
                tgt_d   = cnt_q;
                state_d = S_PUT;
              end
            end
            ACT_FIND_KEY: begin
              if (hit) begin
                ok_d    = 1'b1;
                shown_d = mem_rdata_i;
              end
            end
            ACT_REM_KEY: begin
              if (hit) begin
                if (last) begin
                  cnt_d = cnt_m1;
                  ok_d  = 1'b1;
                end else begin
                  tgt_d   = ridx_q;
                  ia_d    = ridx_p1;
                  iss_d   = 1'b1;
                  state_d = S_SHDN;
                end
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      S_SHUP: begin
        // read k-1, write k, walking down; the write trails the read by two entries
        rv_d = iss_q;
        if (iss_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = to_idx(ia_q);
          ridx_d      = ia_q;
          if (ia_q == tgt_q) begin
            iss_d = 1'b0;
          end else begin
            ia_d = ia_m1;
          end
        end
        if (rv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = to_idx(ridx_p1);
          mem_wdata_o = mem_rdata_i;
          if (ridx_q == tgt_q) begin
            state_d = S_PUT;
          end
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = to_idx(tgt_q);
        mem_wdata_o = nrec_q;
        cnt_d       = cnt_q + ONE_C;
        ok_d        = 1'b1;
        state_d     = S_FIN;
      end

      S_SHDN: begin
        // read k+1, write k, walking up
        rv_d = iss_q;
        if (iss_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = to_idx(ia_q);
          ridx_d      = ia_q;
          if (ia_q == cnt_m1) begin
            iss_d = 1'b0;
          end else begin
            ia_d = ia_p1;
          end
        end
        if (rv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = to_idx(ridx_m1);
          mem_wdata_o = mem_rdata_i;
          if (last) begin
            cnt_d   = cnt_m1;
            ok_d    = 1'b1;
            rv_d    = 1'b0;
            state_d = S_FIN;
          end
        end
      end

      S_RDW: begin
        ok_d    = 1'b1;
        shown_d = mem_rdata_i;
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!ov_q || rsp.ready) begin
          ov_d      = 1'b1;
          out_ok_d  = ok_q;
          out_rec_d = shown_q;
          out_cnt_d = cnt_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= ACT_INS_END;
      nrec_q    <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      tgt_q     <= '0;
      ia_q      <= '0;
      ridx_q    <= '0;
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      ok_q      <= 1'b0;
      shown_q   <= '0;
      ov_q      <= 1'b0;
      out_ok_q  <= 1'b0;
      out_rec_q <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      nrec_q    <= nrec_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      tgt_q     <= tgt_d;
      ia_q      <= ia_d;
      ridx_q    <= ridx_d;
      iss_q     <= iss_d;
      rv_q      <= rv_d;
      ok_q      <= ok_d;
      shown_q   <= shown_d;
      ov_q      <= ov_d;
      out_ok_q  <= out_ok_d;
      out_rec_q <= out_rec_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  assign req.ready          = (state_q == S_IDLE);
  assign rsp.valid          = ov_q;
  assign rsp.ok             = out_ok_q;
  assign rsp.out_key        = out_rec_q.key;
  assign rsp.out_word_one   = out_rec_q.word_one;
  assign rsp.out_word_two   = out_rec_q.word_two;
  assign rsp.out_word_three = out_rec_q.word_three;
  assign rsp.entries        = ENT_W'(out_cnt_q);
  assign rsp.is_full        = (out_cnt_q == CAP_C);
  assign rsp.is_empty       = (out_cnt_q == '0);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP_C)
    else $error("record count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + ONE_C || $past(cnt_q) == cnt_q + ONE_C))
    else $error("record count moved by more than one");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CNT_W'(mem_waddr_o) < CAP_C))
    else $error("memory write beyond capacity");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same entry in one cycle");
`endif

endmodule

/* sv/bounded_sorted_record_list.sv */
// keyed actions, sorted inserts and front inserts and removals walk the memory: they scan,
// shift or both; removals at the end, appends, reads by position and instant failures do not;
// a shift does one memory read and one write per cycle
// one transaction at a time; the request side is ready again when the result register loads
// reset clears the record count and the handshake state; record memory is not cleared
module bounded_sorted_record_list #(
  parameter int CAPACITY = bsrl_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsrl_req_if.sink   req_i,
  bsrl_rsp_if.source rsp_o
);
  import bsrl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  rec_t             mem_rdata;

  bsrl_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bsrl_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* verif/record_list_checker.sv */
// checker that predicts record list responses and compares them field by field
module record_list_checker #(
  parameter int CAPACITY = bsrl_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic [bsrl_pkg::ACT_W-1:0]   req_action_i,
  input  logic signed [31:0]           req_key_i,
  input  logic [31:0]                  req_word_one_i,
  input  logic [31:0]                  req_word_two_i,
  input  logic [31:0]                  req_word_three_i,
  input  logic [bsrl_pkg::POS_W-1:0]   req_position_i,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_ready_i,
  input  logic                         rsp_ok_i,
  input  logic signed [31:0]           rsp_out_key_i,
  input  logic [31:0]                  rsp_out_word_one_i,
  input  logic [31:0]                  rsp_out_word_two_i,
  input  logic [31:0]                  rsp_out_word_three_i,
  input  logic [bsrl_pkg::ENT_W-1:0]   rsp_entries_i,
  input  logic                         rsp_is_full_i,
  input  logic                         rsp_is_empty_i,
  output int                           pending_o,
  output int                           mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bsrl_pkg::*;

  typedef struct packed {
    logic             ok;
    rec_t             rec;
    logic [ENT_W-1:0] entries;
    logic             is_full;
    logic             is_empty;
  } list_rsp_t;

  rec_t      shelf [CAPACITY];
  int        held;
  list_rsp_t awaited_rsp_q [$];
  int        mismatches;
  list_rsp_t want;
  rec_t      incoming;

  function automatic int first_with_key(input logic signed [31:0] key);
    int i;
    i = 0;
    while (i < held && shelf[i].key != key) i++;
    return i;
  endfunction

  function automatic void drop_at(input int slot);
    int k;
    for (k = slot; k + 1 < held; k++) shelf[k] = shelf[k+1];
    held--;
  endfunction

  // applies one transaction to the shadow list and returns the response it should give
  function automatic list_rsp_t apply_list_action(input action_e act, input rec_t rec,
                                                  input logic [POS_W-1:0] pos);
    list_rsp_t r;
    int        slot;
    int        k;
    r = '0;
    case (act)
      ACT_INS_END, ACT_INS_FRONT, ACT_INS_SORTED: begin
        if (held < CAPACITY) begin
          if (act == ACT_INS_END) begin
            slot = held;
          end else if (act == ACT_INS_FRONT) begin
            slot = 0;
          end else begin
            // goes ahead of the first key that is not smaller
            slot = 0;
            while (slot < held && $signed(shelf[slot].key) < $signed(rec.key)) slot++;
          end
          for (k = held; k > slot; k--) shelf[k] = shelf[k-1];
          shelf[slot] = rec;
          held++;
          r.ok = 1'b1;
        end
      end
      ACT_READ_POS: begin
        if (pos >= 1 && pos <= held) begin
          r.rec = shelf[pos-1];
          r.ok  = 1'b1;
        end
      end
      ACT_FIND_KEY: begin
        slot = first_with_key(rec.key);
        if (slot < held) begin
          r.rec = shelf[slot];
          r.ok  = 1'b1;
        end
      end
      ACT_REM_END: begin
        if (held > 0) begin
          held--;
          r.ok = 1'b1;
        end
      end
      ACT_REM_FRONT: begin
        if (held > 0) begin
          drop_at(0);
          r.ok = 1'b1;
        end
      end
      default: begin
        slot = first_with_key(rec.key);
        if (slot < held) begin
          drop_at(slot);
          r.ok = 1'b1;
        end
      end
    endcase
    r.entries  = held[ENT_W-1:0];
    r.is_full  = (held == CAPACITY);
    r.is_empty = (held == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expected_val,
                             input logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected_val, actual_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      awaited_rsp_q.delete();
      mismatches = 0;
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp_ok_i));
          check_field("out_key", want.rec.key, rsp_out_key_i);
          check_field("out_word_one", want.rec.word_one, rsp_out_word_one_i);
          check_field("out_word_two", want.rec.word_two, rsp_out_word_two_i);
          check_field("out_word_three", want.rec.word_three, rsp_out_word_three_i);
          check_field("entries", 32'(want.entries), 32'(rsp_entries_i));
          check_field("is_full", 32'(want.is_full), 32'(rsp_is_full_i));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty_i));
        end
      end
      if (req_valid_i && req_ready_i) begin
        incoming.key        = req_key_i;
        incoming.word_one   = req_word_one_i;
        incoming.word_two   = req_word_two_i;
        incoming.word_three = req_word_three_i;
        awaited_rsp_q.push_back(apply_list_action(action_e'(req_action_i), incoming,
                                                  req_position_i));
      end
      pending_o <= awaited_rsp_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

/* verif/tb_bounded_sorted_record_list.sv */
// testbench top of the bounded sorted record list: stimulus, idling and verdict
module tb_bounded_sorted_record_list;
  timeunit 1ns;
  timeprecision 1ps;

  import bsrl_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int WINDOW       = 200;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF + 16;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   pending;
  int   mismatches;

  bsrl_req_if req_if ();
  bsrl_rsp_if rsp_if ();

  bounded_sorted_record_list #(
    .CAPACITY (CAPACITY_DEF)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  record_list_checker #(
    .CAPACITY (CAPACITY_DEF)
  ) u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_valid_i          (req_if.valid),
    .req_ready_i          (req_if.ready),
    .req_action_i         (req_if.action),
    .req_key_i            (req_if.key),
    .req_word_one_i       (req_if.word_one),
    .req_word_two_i       (req_if.word_two),
    .req_word_three_i     (req_if.word_three),
    .req_position_i       (req_if.position),
    .rsp_valid_i          (rsp_if.valid),
    .rsp_ready_i          (rsp_if.ready),
    .rsp_ok_i             (rsp_if.ok),
    .rsp_out_key_i        (rsp_if.out_key),
    .rsp_out_word_one_i   (rsp_if.out_word_one),
    .rsp_out_word_two_i   (rsp_if.out_word_two),
    .rsp_out_word_three_i (rsp_if.out_word_three),
    .rsp_entries_i        (rsp_if.entries),
    .rsp_is_full_i        (rsp_if.is_full),
    .rsp_is_empty_i       (rsp_if.is_empty),
    .pending_o            (pending),
    .mismatches_o         (mismatches)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_item(input action_e act, input logic signed [31:0] key,
                           input logic [31:0] w1, input logic [31:0] w2,
                           input logic [31:0] w3, input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.key        <= key;
    req_if.word_one   <= w1;
    req_if.word_two   <= w2;
    req_if.word_three <= w3;
    req_if.position   <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // mostly a small pool so finds and keyed removals hit
  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return int'($urandom_range(15)) - 8;
    if (roll < 80) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(99) < 85) return POS_W'($urandom_range(CAPACITY_DEF + 2));
    return POS_W'($urandom_range(127));
  endfunction

  // growing windows favor inserts, shrinking windows favor removals
  task automatic send_random_item(input bit grow);
    int      roll;
    action_e act;
    roll = $urandom_range(99);
    if (roll < (grow ? 60 : 20)) begin
      act = action_e'($urandom_range(ACT_INS_SORTED, ACT_INS_END));
    end else if (roll < (grow ? 80 : 40)) begin
      act = $urandom_range(1) ? ACT_READ_POS : ACT_FIND_KEY;
    end else begin
      act = action_e'($urandom_range(ACT_REM_KEY, ACT_REM_END));
    end
    send_item(act, pick_key(), $urandom(), $urandom(), $urandom(), pick_position());
  endtask

  initial begin
    int n;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_INS_END;
    req_if.key        <= '0;
    req_if.word_one   <= '0;
    req_if.word_two   <= '0;
    req_if.word_three <= '0;
    req_if.position   <= '0;
    send_idle_pct  = 21;
    recv_stall_pct = 72;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list failures
    send_item(ACT_REM_END, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_FRONT, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_KEY, 32'sd5, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_FIND_KEY, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd1);
    // key extremes, sorted insert with an equal key
    send_item(ACT_INS_END, 32'sh7fff_ffff, '1, '1, '1, 7'd0);
    send_item(ACT_INS_FRONT, 32'sh8000_0000, '0, '0, '0, 7'd0);
    send_item(ACT_INS_SORTED, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_INS_SORTED, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_INS_SORTED, -32'sd1, $urandom(), $urandom(), $urandom(), 7'd0);
    // positions around the valid range
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd1);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd5);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd6);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd127);
    // duplicates and absent keys
    send_item(ACT_FIND_KEY, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_FIND_KEY, 32'sd12345, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_KEY, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_KEY, 32'sd12345, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_FIND_KEY, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_FRONT, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_REM_END, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd0);
    send_item(ACT_READ_POS, 32'sd0, $urandom(), $urandom(), $urandom(), 7'd1);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 72;
        recv_stall_pct = 21;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_random_item(((n / WINDOW) % 2) == 0);
    end
    req_if.valid <= 1'b0;

    // the checker count is registered, so it trails the last acceptance
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
